/* rtl/scba_pkg.sv */
package scba_pkg;

	localparam int NumClasses   = 4;
	localparam int MaxSlots     = 256;
	localparam int HeapBytes    = 4096;
	localparam int HeaderBytes  = 12;
	localparam int BytesPerCls  = MaxSlots / 8;
	localparam int MemDepth     = NumClasses * BytesPerCls;
	localparam int MemAw        = $clog2(MemDepth);
	localparam int ByteAw       = $clog2(BytesPerCls);

	localparam logic [2:0] StOk         = 3'd0;
	localparam logic [2:0] StBadSize    = 3'd1;
	localparam logic [2:0] StNoSlot     = 3'd2;
	localparam logic [2:0] StBadPtr     = 3'd3;
	localparam logic [2:0] StUnaligned  = 3'd4;
	localparam logic [2:0] StDoubleFree = 3'd5;

	localparam logic OpAlloc = 1'b0;
	localparam logic OpFree  = 1'b1;

	localparam logic [2:0] RegBlock0 = 3'd0;
	localparam logic [2:0] RegSlots0 = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [11:0] request_bytes;
		logic [11:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] granted_offset;
		logic [1:0]  granted_class;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAYOUT,
		S_ACLASS,
		S_AREAD,
		S_ACHECK,
		S_FFIND,
		S_FDIV,
		S_FREAD,
		S_FCHECK,
		S_DONE
	} state_t;

endpackage

/* rtl/scba_div.sv */
// Restoring divider: 12-bit dividend by 12-bit divisor, one quotient bit a cycle
module scba_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [11:0] dividend,
	input  logic [11:0] divisor,
	output logic        done,
	output logic [11:0] quotient,
	output logic [11:0] remainder
);
	import scba_pkg::*;

	logic [11:0] quo_q;
	logic [12:0] rem_q;
	logic [11:0] dsr_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic [12:0] trial;
	logic [12:0] shifted;

	assign shifted = {rem_q[11:0], quo_q[11]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 4'd12;
		end else if (run_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!trial[12]) begin
				rem_q <= trial;
				quo_q <= {quo_q[10:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[10:0], 1'b0};
			end
		end
	end

	assign done      = !run_q && cnt_q == 4'd0 && !go;
	assign quotient  = quo_q;
	assign remainder = rem_q[11:0];
endmodule

/* rtl/size_class_bitmap_pool_allocator.sv */
// Pool allocator with four size classes, each tracked by a used-slot bitmap held in a
// 128 x 8 synchronous RAM. One request at a time: busy is high from acceptance until the
// result strobe, and drops the cycle after it. Each request starts with a layout pass over
// the classes; an allocate then tries the classes in turn and reads bitmap bytes of each
// class that fits, and a free looks up the class, runs the serial divider, then reads and
// updates the bitmap before the result. An unaligned free skips the bitmap step, and a
// free whose offset hits no class skips the divider too. After reset a clearing pass
// sweeps the RAM, during which busy is high. The result is shown on rsp for one cycle with
// done high and cannot be held off.
module size_class_bitmap_pool_allocator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  scba_pkg::req_t        req,
	output logic                  done,
	output scba_pkg::rsp_t        rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import scba_pkg::*;

	// configuration registers
	logic [11:0] blk_q [NumClasses];
	logic [8:0]  cnt_q [NumClasses];
	logic [2:0]  ridx;
	assign ridx   = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumClasses; c++) begin
				blk_q[c] <= 12'(16 << c);
				cnt_q[c] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			if (ridx < RegSlots0) blk_q[ridx[1:0]] <= pwdata[11:0];
			else cnt_q[ridx[1:0]] <= pwdata[8:0];
		end
	end

	always_comb begin
		if (ridx < RegSlots0) prdata = {20'd0, blk_q[ridx[1:0]]};
		else prdata = {23'd0, cnt_q[ridx[1:0]]};
	end

	// bitmap RAM
	logic [7:0]       mem [MemDepth];
	logic [MemAw-1:0] raddr, waddr;
	logic             we;
	logic [7:0]       wdata, rdata_q;
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// layout registers; wide enough for a layout that runs far past the heap
	logic [8:0]  nsl_q   [NumClasses];
	logic [23:0] dstart_q[NumClasses];
	logic [23:0] dend_q  [NumClasses];
	logic [23:0] pos_q;

	state_t      st_q, st_d;
	logic        clr_q;
	logic [MemAw-1:0] clra_q;
	req_t        rq_q;
	logic [1:0]  cls_q;
	logic [8:0]  slot_q;       // byte-aligned scan slot
	logic [2:0]  bit_q;
	logic [2:0]  stat_q;
	logic [11:0] goff_q;
	logic [1:0]  gcls_q;
	logic [23:0] sbase_q;      // dstart + slot*blk during scan
	logic        div_go;
	logic        div_done;
	logic [11:0] quo, rem;

	// layout step for class cls_q
	logic [8:0]  nc;
	logic [20:0] span;
	always_comb begin
		nc = (cnt_q[cls_q] > 9'(MaxSlots)) ? 9'(MaxSlots) : cnt_q[cls_q];
		if (blk_q[cls_q] == 12'd0) nc = '0;
		span = 21'(nc) * 21'(blk_q[cls_q]);
	end

	// lowest free bit in the fetched byte, limited to existing slots
	logic [7:0]  freev;
	logic [2:0]  fbit;
	logic        fany;
	logic [23:0] send;
	logic        sexist;
	always_comb begin
		for (int b = 0; b < 8; b++)
			freev[b] = !rdata_q[b] && (slot_q + 9'(b) < nsl_q[cls_q]);
		fbit = '0;
		fany = 1'b0;
		for (int b = 7; b >= 0; b--)
			if (freev[b]) begin
				fbit = 3'(b);
				fany = 1'b1;
			end
	end

	// free class lookup
	logic [1:0] hit;
	logic       hitv;
	always_comb begin
		hit  = '0;
		hitv = 1'b0;
		for (int c = NumClasses - 1; c >= 0; c--)
			if (nsl_q[c] != 0 && 24'(rq_q.release_offset) >= dstart_q[c]
				&& 24'(rq_q.release_offset) < dend_q[c]) begin
				hit  = 2'(c);
				hitv = 1'b1;
			end
	end

	logic [11:0] rel;
	assign rel = rq_q.release_offset - dstart_q[hit][11:0];

	scba_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(rel),
		.divisor(blk_q[hit]), .done(div_done), .quotient(quo), .remainder(rem)
	);

	// address of the grant candidate and existence of the freed slot
	logic [23:0] gaddr;
	logic [24:0] fend;
	assign gaddr = sbase_q + 24'(15'(fbit) * 15'(blk_q[cls_q]));
	assign send  = gaddr + 24'(blk_q[cls_q]);
	assign fend  = 25'(dstart_q[hit]) + (25'(quo) + 25'd1) * 25'(blk_q[hit]);
	assign sexist = fend <= 25'(HeapBytes) && quo < 12'(nsl_q[hit]);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE:   if (start && !clr_q) st_d = S_LAYOUT;
			S_LAYOUT: if (cls_q == 2'(NumClasses - 1))
				st_d = (rq_q.operation == OpAlloc) ? S_ACLASS : S_FFIND;
			S_ACLASS: begin
				if (rq_q.request_bytes == 0) st_d = S_DONE;
				else if (nsl_q[cls_q] != 0 && blk_q[cls_q] >= rq_q.request_bytes)
					st_d = S_AREAD;
				else if (cls_q == 2'(NumClasses - 1)) st_d = S_DONE;
			end
			S_AREAD:  st_d = S_ACHECK;
			S_ACHECK: begin
				if ((fany && send <= 24'(HeapBytes)) || cls_q == 2'(NumClasses - 1))
					st_d = (fany && send <= 24'(HeapBytes)) ? S_DONE :
						((slot_q + 9'd8 < nsl_q[cls_q] && !fany) ? S_AREAD : S_DONE);
				else if (!fany && slot_q + 9'd8 < nsl_q[cls_q]) st_d = S_AREAD;
				else st_d = S_ACLASS;
			end
			S_FFIND:  st_d = hitv ? S_FDIV : S_DONE;
			S_FDIV:   if (div_done && !div_go)
				st_d = (rem != 0 || !sexist) ? S_DONE : S_FREAD;
			S_FREAD:  st_d = S_FCHECK;
			S_FCHECK: st_d = S_DONE;
			S_DONE:   st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
	end

	// RAM and divider control
	always_comb begin
		we     = 1'b0;
		waddr  = {cls_q, slot_q[ByteAw+2:3]};
		wdata  = rdata_q;
		raddr  = {cls_q, slot_q[ByteAw+2:3]};
		div_go = st_q == S_FFIND && hitv;
		if (clr_q) begin
			we    = 1'b1;
			waddr = clra_q;
			wdata = '0;
		end else if (st_q == S_ACHECK && fany && send <= 24'(HeapBytes)) begin
			we = 1'b1;
			wdata = rdata_q | (8'd1 << fbit);
		end else if (st_q == S_FCHECK && rdata_q[bit_q]) begin
			we = 1'b1;
			wdata = rdata_q & ~(8'd1 << bit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			clr_q  <= 1'b1;
			clra_q <= '0;
		end else begin
			st_q <= st_d;
			if (clr_q) begin
				clra_q <= clra_q + 1'b1;
				if (clra_q == MemAw'(MemDepth - 1)) clr_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				rq_q   <= req;
				cls_q  <= '0;
				pos_q  <= 24'(NumClasses * HeaderBytes);
				stat_q <= StBadSize;
				goff_q <= '0;
				gcls_q <= '0;
			end
			S_LAYOUT: begin
				nsl_q[cls_q]    <= nc;
				dstart_q[cls_q] <= pos_q + 24'((nc + 9'd7) >> 3);
				dend_q[cls_q]   <= pos_q + 24'((nc + 9'd7) >> 3) + 24'(span);
				pos_q           <= pos_q + 24'((nc + 9'd7) >> 3) + 24'(span);
				cls_q           <= cls_q + 2'd1;
				slot_q          <= '0;
				sbase_q         <= 24'(NumClasses * HeaderBytes) + 24'((nc + 9'd7) >> 3);
				if (rq_q.operation == OpFree) stat_q <= StBadPtr;
			end
			S_ACLASS: begin
				slot_q  <= '0;
				sbase_q <= dstart_q[cls_q];
				if (rq_q.request_bytes != 0 && nsl_q[cls_q] != 0
					&& blk_q[cls_q] >= rq_q.request_bytes) begin
					stat_q <= StNoSlot;
				end else cls_q <= cls_q + 2'd1;
			end
			S_ACHECK: begin
				if (fany && send <= 24'(HeapBytes)) begin
					stat_q <= StOk;
					goff_q <= gaddr[11:0];
					gcls_q <= cls_q;
				end else if (!fany && slot_q + 9'd8 < nsl_q[cls_q]) begin
					slot_q  <= slot_q + 9'd8;
					sbase_q <= sbase_q + (24'(blk_q[cls_q]) << 3);
				end else cls_q <= cls_q + 2'd1;
			end
			S_FDIV: if (div_done) begin
				cls_q  <= hit;
				slot_q <= {quo[8:3], 3'd0};
				bit_q  <= quo[2:0];
				if (rem != 0) begin
					stat_q <= StUnaligned;
					gcls_q <= hit;
				end else if (sexist) gcls_q <= hit;
			end
			S_FCHECK: stat_q <= rdata_q[bit_q] ? StOk : StDoubleFree;
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		busy = st_q != S_IDLE || clr_q;
		done = st_q == S_DONE;
		rsp.status         = stat_q;
		rsp.granted_offset = goff_q;
		rsp.granted_class  = gcls_q;
	end
endmodule

/* verif/size_class_bitmap_pool_allocator_test.sv */
`timescale 1ns / 100ps

module size_class_bitmap_pool_allocator_test;
	import scba_pkg::*;

	localparam int CycleLimit = 1500000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	size_class_bitmap_pool_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow allocator state
	logic [11:0] blk_bytes [NumClasses];
	logic [8:0]  slot_cnt [NumClasses];
	logic        slot_used [NumClasses][MaxSlots];
	int          lay_start [NumClasses];
	int          lay_n [NumClasses];

	req_t request_backlog [$];
	rsp_t owed_rsp [$];
	int   cycles;
	int   errors;
	int   n_req;
	int   n_status [8];
	bit   took;
	int   gap_cnt;
	bit   no_gaps;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// recompute class layout from the current register values
	task automatic build_layout();
		int pos;
		int n;
		pos = NumClasses * HeaderBytes;
		for (int c = 0; c < NumClasses; c++) begin
			n = slot_cnt[c];
			if (n > MaxSlots)
				n = MaxSlots;
			if (blk_bytes[c] == 0)
				n = 0;
			lay_n[c] = n;
			lay_start[c] = pos + (n + 7) / 8;
			pos = lay_start[c] + n * blk_bytes[c];
		end
	endtask

	function automatic bit slot_present(int c, int s);
		if (s >= lay_n[c])
			return 0;
		return lay_start[c] + (s + 1) * blk_bytes[c] <= HeapBytes;
	endfunction

	// expected outcome of one request; updates the shadow bitmap
	task automatic allocator_outcome(input req_t r, output rsp_t o);
		bit fits;
		bit got;
		int hit;
		int rel;
		int s;
		build_layout();
		o = '0;
		if (r.operation == OpAlloc) begin
			fits = 0;
			got = 0;
			o.status = StBadSize;
			if (r.request_bytes != 0) begin
				for (int c = 0; c < NumClasses && !got; c++) begin
					if (lay_n[c] == 0 || blk_bytes[c] < r.request_bytes)
						continue;
					fits = 1;
					for (int k = 0; k < lay_n[c]; k++) begin
						if (!slot_present(c, k))
							break;
						if (!slot_used[c][k]) begin
							slot_used[c][k] = 1;
							o.granted_offset = 12'(lay_start[c] + k * blk_bytes[c]);
							o.granted_class = 2'(c);
							got = 1;
							break;
						end
					end
				end
				if (got)
					o.status = StOk;
				else if (fits)
					o.status = StNoSlot;
			end
		end else begin
			hit = -1;
			o.status = StBadPtr;
			for (int c = 0; c < NumClasses; c++) begin
				if (lay_n[c] != 0 && r.release_offset >= lay_start[c] &&
				    r.release_offset < lay_start[c] + lay_n[c] * blk_bytes[c]) begin
					hit = c;
					break;
				end
			end
			if (hit >= 0) begin
				rel = r.release_offset - lay_start[hit];
				if (rel % blk_bytes[hit] != 0) begin
					o.status = StUnaligned;
					o.granted_class = 2'(hit);
				end else begin
					s = rel / blk_bytes[hit];
					if (slot_present(hit, s)) begin
						o.granted_class = 2'(hit);
						if (!slot_used[hit][s]) begin
							o.status = StDoubleFree;
						end else begin
							slot_used[hit][s] = 0;
							o.status = StOk;
						end
					end
				end
			end
		end
	endtask

	// sample requests and responses
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got_r;
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t timeout with %0d responses owed", $time, owed_rsp.size());
			$display("size_class_bitmap_pool_allocator_test: FAIL");
			$finish;
		end
		took = 0;
		if (arst_n && done) begin
			got_r = rsp;
			if (owed_rsp.size() == 0) begin
				errors++;
				$display("%0t unexpected response %p", $time, got_r);
			end else begin
				want = owed_rsp.pop_front();
				if (got_r.status !== want.status || got_r.granted_offset !== want.granted_offset
				    || got_r.granted_class !== want.granted_class) begin
					errors++;
					$display("%0t mismatch: expected %p actual %p", $time, want, got_r);
				end
			end
		end
		if (arst_n && start && !busy) begin
			allocator_outcome(req, want);
			owed_rsp.push_back(want);
			n_req++;
			n_status[want.status]++;
			took = 1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (took || !start)) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				start <= 1'b0;
			end else if (request_backlog.size() != 0) begin
				req <= request_backlog.pop_front();
				start <= 1'b1;
				gap_cnt <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic reg_write(input int idx, input int val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < NumClasses)
			blk_bytes[idx] = 12'(val);
		else
			slot_cnt[idx - NumClasses] = 9'(val);
	endtask

	task automatic set_classes(input int b0, b1, b2, b3, n0, n1, n2, n3);
		reg_write(RegBlock0 + 0, b0);
		reg_write(RegBlock0 + 1, b1);
		reg_write(RegBlock0 + 2, b2);
		reg_write(RegBlock0 + 3, b3);
		reg_write(RegSlots0 + 0, n0);
		reg_write(RegSlots0 + 1, n1);
		reg_write(RegSlots0 + 2, n2);
		reg_write(RegSlots0 + 3, n3);
	endtask

	task automatic push_req(input logic op, input int bytes, input int off);
		req_t r;
		r.operation = op;
		r.request_bytes = 12'(bytes);
		r.release_offset = 12'(off);
		request_backlog.push_back(r);
	endtask

	// hold off until every request is answered and the block is quiet
	task automatic drain();
		while (request_backlog.size() != 0 || start || owed_rsp.size() != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// random mix: mostly plausible allocs and frees of real slots, some noise
	task automatic random_batch(input int count);
		int r;
		int c;
		int off;
		int maxb;
		build_layout();
		maxb = 1;
		for (int k = 0; k < NumClasses; k++)
			if (blk_bytes[k] > maxb)
				maxb = blk_bytes[k];
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 52) begin
				if (r < 3)
					push_req(OpAlloc, 0, $urandom);
				else if (r < 6)
					push_req(OpAlloc, $urandom_range(0, 4095), $urandom);
				else
					push_req(OpAlloc, $urandom_range(1, maxb), $urandom);
			end else begin
				c = $urandom_range(0, NumClasses - 1);
				off = $urandom_range(0, 4095);
				if (lay_n[c] != 0 && r < 92) begin
					off = lay_start[c] + $urandom_range(0, lay_n[c] - 1) * blk_bytes[c];
					if (r >= 85)
						off += $urandom_range(1, 3);
					if (off > 4095)
						off = $urandom_range(0, 4095);
				end
				push_req(OpFree, $urandom, off);
			end
		end
	endtask

	task automatic random_classes();
		int b [NumClasses];
		int n [NumClasses];
		b[0] = $urandom_range(1, 40);
		for (int c = 1; c < NumClasses; c++)
			b[c] = b[c - 1] + $urandom_range(0, 60);
		if ($urandom_range(0, 3) == 0)
			b[$urandom_range(0, 3)] = $urandom_range(0, 4095);
		if ($urandom_range(0, 5) == 0)
			b[$urandom_range(0, 3)] = 0;
		for (int c = 0; c < NumClasses; c++) begin
			n[c] = $urandom_range(0, 20);
			if ($urandom_range(0, 7) == 0)
				n[c] = $urandom_range(0, 511);
		end
		set_classes(b[0], b[1], b[2], b[3], n[0], n[1], n[2], n[3]);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		errors = 0;
		n_req = 0;
		gap_cnt = 0;
		no_gaps = 0;
		took = 0;
		foreach (n_status[i])
			n_status[i] = 0;
		for (int c = 0; c < NumClasses; c++) begin
			blk_bytes[c] = 12'(16 << c);
			slot_cnt[c] = '0;
			for (int s = 0; s < MaxSlots; s++)
				slot_used[c][s] = 0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset layout: no slots at all
		push_req(OpAlloc, 16, 0);
		push_req(OpFree, 0, 100);
		drain();

		// small pools: spill into larger class, every failure kind
		set_classes(16, 32, 64, 128, 3, 9, 2, 1);
		push_req(OpAlloc, 0, 0);
		push_req(OpAlloc, 4095, 4095);
		repeat (4) push_req(OpAlloc, 1, 0);
		push_req(OpAlloc, 128, 0);
		push_req(OpAlloc, 128, 0);
		push_req(OpAlloc, 64, 0);
		push_req(OpFree, 0, 0);
		push_req(OpFree, 0, 4095);
		push_req(OpFree, 0, 50);
		push_req(OpFree, 0, 65);
		push_req(OpFree, 0, 65);
		push_req(OpFree, 0, 98);
		push_req(OpFree, 4095, 517);
		push_req(OpAlloc, 16, 0);
		random_batch(180);
		// sender waits for every answer mid-phase
		drain();
		random_batch(40);
		drain();

		// extremes: zero block size, 1-byte slots, slots past heap end, clamped counts
		no_gaps = 1;
		set_classes(0, 1, 4095, 4095, 511, 256, 256, 256);
		push_req(OpAlloc, 2, 0);
		push_req(OpAlloc, 4095, 0);
		push_req(OpFree, 0, 4095);
		random_batch(200);
		drain();
		no_gaps = 0;

		// unsorted sizes
		set_classes(100, 10, 50, 1, 5, 5, 5, 5);
		random_batch(150);
		drain();

		for (int p = 0; p < 6; p++) begin
			no_gaps = (p == 2);
			random_classes();
			random_batch(170);
			drain();
		end

		set_classes(4095, 4095, 4095, 4095, 0, 1, 0, 0);
		random_batch(30);
		drain();
		repeat (40) @(negedge clk);

		$display("%0d requests over several pool layouts: %0d ok, %0d bad size, %0d no slot,",
			n_req, n_status[StOk], n_status[StBadSize], n_status[StNoSlot]);
		$display("%0d bad pointer, %0d unaligned, %0d double free",
			n_status[StBadPtr], n_status[StUnaligned], n_status[StDoubleFree]);
		if (errors == 0 && owed_rsp.size() == 0) begin
			$display("size_class_bitmap_pool_allocator_test: PASS");
		end else begin
			$display("size_class_bitmap_pool_allocator_test: FAIL");
		end
		$finish;
	end

endmodule
